FILE: hdl/shc_pkg.sv
// Shared types, codes and constants of the shadow heap checker.
package shc_pkg;

   localparam int CMD_W    = 2;
   localparam int ADDR_W   = 32;
   localparam int SIZE_W   = 17;
   localparam int STATUS_W = 4;
   localparam int COUNT_W  = 32;

   localparam int ARENA_BYTES_DEF   = 65536;
   localparam int GRANULE_BYTES_DEF = 8;
   localparam int REDZONE_BYTES_DEF = 16;

   typedef enum logic [CMD_W-1:0] {
      CMD_ALLOC = 2'd0,
      CMD_FREE  = 2'd1,
      CMD_CHECK = 2'd2
   } cmd_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK           = 4'd0,
      ST_IGNORED      = 4'd1,
      ST_NO_ROOM      = 4'd2,
      ST_UNDERFLOW    = 4'd3,
      ST_OVERFLOW     = 4'd4,
      ST_USE_AFTER    = 4'd5,
      ST_INVALID_FREE = 4'd6,
      ST_DOUBLE_FREE  = 4'd7,
      ST_NOT_OWNED    = 4'd8
   } status_type;

   typedef struct packed {
      logic              valid;
      logic              freed;
      logic [SIZE_W-1:0] size;
   } hdr_type;

   typedef enum logic [3:0] {
      S_CLEAR,
      S_IDLE,
      S_DECODE,
      S_AMARK,
      S_FRD,
      S_FEVAL,
      S_FMARK,
      S_CRD,
      S_CEVAL,
      S_RESP
   } state_type;

endpackage

FILE: hdl/shc_ifs.sv
// Handshake channel interfaces for requests and responses.
interface shc_req_if
   import shc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    command;
   logic [ADDR_W-1:0]   address;
   logic [SIZE_W-1:0]   size;
   modport source (output valid, command, address, size, input ready);
   modport sink (input valid, command, address, size, output ready);
endinterface

interface shc_rsp_if
   import shc_pkg::*;
();
   logic                valid;
   logic                ready;
   logic [STATUS_W-1:0] status;
   logic [ADDR_W-1:0]   result_address;
   logic [SIZE_W-1:0]   alloc_bytes;
   logic [SIZE_W-1:0]   alloc_peak;
   logic [COUNT_W-1:0]  error_count;
   modport source (output valid, status, result_address, alloc_bytes, alloc_peak,
                   error_count, input ready);
   modport sink (input valid, status, result_address, alloc_bytes, alloc_peak,
                 error_count, output ready);
endinterface

FILE: hdl/shadow_heap_checker.sv
// Top level of the shadow heap checker: sequencer, statistics and shadow stores.
//
// The block keeps a shadow code for every granule of a bump-allocated arena and a
// header table for allocation records, both in on-chip RAM. After reset it first
// sweeps both memories, one granule per cycle, over all ARENA_BYTES / GRANULE_BYTES
// granules (8192 at the defaults); no transaction is accepted during that sweep,
// although arena_base may be written. Thereafter one request transaction is
// processed at a time. An allocate writes one shadow code per granule of its
// footprint (two redzones and the rounded payload); a free reads and updates the
// header and then poisons each payload granule; a check reads and tests each
// shadow granule touched, and a check that hits a fault stops at that granule.
// The shadow RAM is read or written once per granule step. A finished response
// is held in an output register, so the next request is accepted while it waits
// to be taken. Write arena_base only while the block is idle.
module shadow_heap_checker
   import shc_pkg::*;
#(
   parameter int ARENA_BYTES   = ARENA_BYTES_DEF,
   parameter int GRANULE_BYTES = GRANULE_BYTES_DEF,
   parameter int REDZONE_BYTES = REDZONE_BYTES_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_wr_en,
   input  logic [ADDR_W-1:0] csr_wr_data,
   shc_req_if.sink           req_ch,
   shc_rsp_if.source         rsp_ch
);
   localparam int DEPTH   = ARENA_BYTES / GRANULE_BYTES;
   localparam int G_W     = $clog2(DEPTH);
   localparam int GSH     = $clog2(GRANULE_BYTES);
   localparam int CODE_W  = $clog2(GRANULE_BYTES + 3);
   localparam int SPAN_W  = $clog2(ARENA_BYTES + 2**SIZE_W + 2*REDZONE_BYTES
                                   + GRANULE_BYTES) + 1;
   localparam int LEFT_G  = REDZONE_BYTES / GRANULE_BYTES;
   localparam int HDR_W   = $bits(hdr_type);

   localparam logic [CODE_W-1:0] CODE_LEFT  = CODE_W'(GRANULE_BYTES);
   localparam logic [CODE_W-1:0] CODE_RIGHT = CODE_W'(GRANULE_BYTES + 1);
   localparam logic [CODE_W-1:0] CODE_FREED = CODE_W'(GRANULE_BYTES + 2);

   // Sequencer and request registers.
   state_type            state_ff, state_in;
   logic [CMD_W-1:0]     cmd_ff, cmd_in;
   logic [ADDR_W-1:0]    addr_ff, addr_in;
   logic [SIZE_W-1:0]    size_ff, size_in;

   // Architectural state.
   logic [ADDR_W-1:0]    base_ff, base_in;
   logic [SPAN_W-1:0]    break_ff, break_in;
   logic                 ready_ff, ready_in;
   logic [SIZE_W-1:0]    in_use_ff, in_use_in;
   logic [SIZE_W-1:0]    peak_ff, peak_in;
   logic [COUNT_W-1:0]   fault_ff, fault_in;

   // Walk registers shared by the allocate, free and check loops.
   logic [G_W-1:0]       gptr_ff, gptr_in;
   logic [SPAN_W-1:0]    k_ff, k_in;
   logic [SPAN_W-1:0]    cnt_ff, cnt_in;
   logic [SPAN_W-1:0]    whole_ff, whole_in;
   logic [GSH-1:0]       tail_ff, tail_in;
   logic [SPAN_W-1:0]    b_ff, b_in;
   logic [SPAN_W-1:0]    e_ff, e_in;
   logic [SPAN_W-1:0]    off_ff, off_in;
   logic [G_W-1:0]       hg_ff, hg_in;
   status_type           status_ff, status_in;
   logic [ADDR_W-1:0]    res_ff, res_in;

   // Response register.
   logic                 rsp_valid_ff, rsp_valid_in;
   status_type           rsp_status_ff, rsp_status_in;
   logic [ADDR_W-1:0]    rsp_addr_ff, rsp_addr_in;
   logic [SIZE_W-1:0]    rsp_use_ff, rsp_use_in;
   logic [SIZE_W-1:0]    rsp_peak_ff, rsp_peak_in;
   logic [COUNT_W-1:0]   rsp_err_ff, rsp_err_in;

   // Memory ports.
   logic                 sh_wr_en;
   logic [G_W-1:0]       sh_wr_addr;
   logic [CODE_W-1:0]    sh_wr_data;
   logic [G_W-1:0]       sh_rd_addr;
   logic [CODE_W-1:0]    sh_rd_data;
   logic                 hd_wr_en;
   logic [G_W-1:0]       hd_wr_addr;
   hdr_type              hd_wr_data;
   logic [HDR_W-1:0]     hd_rd_raw;
   hdr_type              hd_rd;

   // Decode arithmetic.
   logic [SIZE_W-1:0]    sz;
   logic [SPAN_W-1:0]    rounded;
   logic [SPAN_W-1:0]    need;
   logic [ADDR_W-1:0]    off32;
   logic [ADDR_W-1:0]    hoff32;
   logic [SIZE_W-1:0]    use_add;
   logic [SPAN_W-1:0]    rel;
   logic [CODE_W-1:0]    alloc_code;
   logic                 load_rsp;
   logic                 is_error;

   // Granule test results.
   logic                 gc_fault;
   status_type           gc_status;
   logic [SPAN_W-1:0]    gc_fault_byte;
   logic [SPAN_W-1:0]    gc_next;
   logic                 gc_last;

   shc_ram #(.WIDTH(CODE_W), .DEPTH(DEPTH)) u_shadow_ram (
      .clock   (clock),
      .wr_en   (sh_wr_en),
      .wr_addr (sh_wr_addr),
      .wr_data (sh_wr_data),
      .rd_addr (sh_rd_addr),
      .rd_data (sh_rd_data)
   );

   shc_ram #(.WIDTH(HDR_W), .DEPTH(DEPTH)) u_header_ram (
      .clock   (clock),
      .wr_en   (hd_wr_en),
      .wr_addr (hd_wr_addr),
      .wr_data (hd_wr_data),
      .rd_addr (hg_ff),
      .rd_data (hd_rd_raw)
   );

   assign hd_rd = hdr_type'(hd_rd_raw);

   shc_granule_check #(
      .GRANULE_BYTES (GRANULE_BYTES),
      .SPAN_W        (SPAN_W),
      .CODE_W        (CODE_W)
   ) u_granule_check (
      .code         (sh_rd_data),
      .cur_byte     (b_ff),
      .end_byte     (e_ff),
      .fault        (gc_fault),
      .fault_status (gc_status),
      .fault_byte   (gc_fault_byte),
      .next_byte    (gc_next),
      .last         (gc_last)
   );

   // Shared decode arithmetic. A zero-byte allocation counts as one byte.
   always_comb begin
      sz      = (size_ff == '0) ? SIZE_W'(1) : size_ff;
      rounded = ((SPAN_W'(sz) + SPAN_W'(GRANULE_BYTES - 1)) >> GSH) << GSH;
      need    = SPAN_W'(2 * REDZONE_BYTES) + rounded;
      off32   = addr_ff - base_ff;
      hoff32  = off32 - ADDR_W'(REDZONE_BYTES);
      use_add = in_use_ff + sz;
      rel     = k_ff - SPAN_W'(LEFT_G);
      if (k_ff < SPAN_W'(LEFT_G)) begin
         alloc_code = CODE_LEFT;
      end else if (rel < whole_ff) begin
         alloc_code = '0;
      end else if (rel == whole_ff && tail_ff != '0) begin
         alloc_code = CODE_W'(tail_ff);
      end else begin
         alloc_code = CODE_RIGHT;
      end
      load_rsp = (state_ff == S_RESP) && (!rsp_valid_ff || rsp_ch.ready);
      is_error = (status_ff inside {ST_UNDERFLOW, ST_OVERFLOW, ST_USE_AFTER,
                                    ST_INVALID_FREE, ST_DOUBLE_FREE});
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_CLEAR: begin
            if (gptr_ff == G_W'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (cmd_ff)
               CMD_ALLOC: begin
                  if (break_ff + need > SPAN_W'(ARENA_BYTES)) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_AMARK;
                  end
               end
               CMD_FREE: begin
                  if (addr_ff == '0 || addr_ff < base_ff
                      || off32 >= ADDR_W'(ARENA_BYTES)
                      || off32 < ADDR_W'(REDZONE_BYTES) || hoff32[GSH-1:0] != '0) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_FRD;
                  end
               end
               CMD_CHECK: begin
                  if (!ready_ff || addr_ff < base_ff || off32 >= ADDR_W'(ARENA_BYTES)
                      || size_ff == '0) begin
                     state_in = S_RESP;
                  end else begin
                     state_in = S_CRD;
                  end
               end
               default: state_in = S_RESP;
            endcase
         end
         S_AMARK: begin
            if (k_ff == cnt_ff - SPAN_W'(1)) begin
               state_in = S_RESP;
            end
         end
         S_FRD:   state_in = S_FEVAL;
         S_FEVAL: begin
            if (!hd_rd.valid || hd_rd.freed) begin
               state_in = S_RESP;
            end else begin
               state_in = S_FMARK;
            end
         end
         S_FMARK: begin
            if (k_ff == cnt_ff - SPAN_W'(1) || gptr_ff == G_W'(DEPTH - 1)) begin
               state_in = S_RESP;
            end
         end
         S_CRD: begin
            if (b_ff >= SPAN_W'(ARENA_BYTES)) begin
               state_in = S_RESP;
            end else begin
               state_in = S_CEVAL;
            end
         end
         S_CEVAL: begin
            if (gc_fault || gc_last) begin
               state_in = S_RESP;
            end else begin
               state_in = S_CRD;
            end
         end
         S_RESP: begin
            if (load_rsp) begin
               state_in = S_IDLE;
            end
         end
         default: state_in = S_CLEAR;
      endcase
   end

   // Datapath and memory control.
   always_comb begin
      cmd_in     = cmd_ff;
      addr_in    = addr_ff;
      size_in    = size_ff;
      base_in    = csr_wr_en ? csr_wr_data : base_ff;
      break_in   = break_ff;
      ready_in   = ready_ff;
      in_use_in  = in_use_ff;
      peak_in    = peak_ff;
      fault_in   = fault_ff;
      gptr_in    = gptr_ff;
      k_in       = k_ff;
      cnt_in     = cnt_ff;
      whole_in   = whole_ff;
      tail_in    = tail_ff;
      b_in       = b_ff;
      e_in       = e_ff;
      off_in     = off_ff;
      hg_in      = hg_ff;
      status_in  = status_ff;
      res_in     = res_ff;
      sh_wr_en   = 1'b0;
      sh_wr_addr = gptr_ff;
      sh_wr_data = CODE_LEFT;
      sh_rd_addr = b_ff[GSH +: G_W];
      hd_wr_en   = 1'b0;
      hd_wr_addr = gptr_ff;
      hd_wr_data = '0;

      rsp_valid_in  = rsp_valid_ff && !rsp_ch.ready;
      rsp_status_in = rsp_status_ff;
      rsp_addr_in   = rsp_addr_ff;
      rsp_use_in    = rsp_use_ff;
      rsp_peak_in   = rsp_peak_ff;
      rsp_err_in    = rsp_err_ff;

      case (state_ff)
         S_CLEAR: begin
            // Every granule starts as left redzone with no header.
            sh_wr_en = 1'b1;
            hd_wr_en = 1'b1;
            gptr_in  = gptr_ff + G_W'(1);
         end
         S_IDLE: begin
            if (req_ch.valid) begin
               cmd_in  = req_ch.command;
               addr_in = req_ch.address;
               size_in = req_ch.size;
            end
         end
         S_DECODE: begin
            res_in    = '0;
            status_in = ST_OK;
            k_in      = '0;
            case (cmd_ff)
               CMD_ALLOC: begin
                  ready_in = 1'b1;
                  if (break_ff + need > SPAN_W'(ARENA_BYTES)) begin
                     status_in = ST_NO_ROOM;
                  end else begin
                     break_in  = break_ff + need;
                     gptr_in   = break_ff[GSH +: G_W];
                     cnt_in    = need >> GSH;
                     whole_in  = SPAN_W'(sz) >> GSH;
                     tail_in   = sz[GSH-1:0];
                     res_in    = base_ff + ADDR_W'(break_ff) + ADDR_W'(REDZONE_BYTES);
                     in_use_in = use_add;
                     peak_in   = (use_add > peak_ff) ? use_add : peak_ff;
                  end
               end
               CMD_FREE: begin
                  hg_in  = hoff32[GSH +: G_W];
                  off_in = off32[SPAN_W-1:0];
                  if (addr_ff == '0 || addr_ff < base_ff
                      || off32 >= ADDR_W'(ARENA_BYTES)) begin
                     status_in = ST_NOT_OWNED;
                  end else if (off32 < ADDR_W'(REDZONE_BYTES) || hoff32[GSH-1:0] != '0) begin
                     status_in = ST_INVALID_FREE;
                  end
               end
               CMD_CHECK: begin
                  off_in = off32[SPAN_W-1:0];
                  b_in   = off32[SPAN_W-1:0];
                  e_in   = off32[SPAN_W-1:0] + SPAN_W'(size_ff);
                  if (!ready_ff || addr_ff < base_ff || off32 >= ADDR_W'(ARENA_BYTES)) begin
                     status_in = ST_IGNORED;
                  end
               end
               default: status_in = ST_IGNORED;
            endcase
         end
         S_AMARK: begin
            sh_wr_en   = 1'b1;
            sh_wr_data = alloc_code;
            if (k_ff == '0) begin
               hd_wr_en   = 1'b1;
               hd_wr_data = '{valid: 1'b1, freed: 1'b0, size: sz};
            end
            gptr_in = gptr_ff + G_W'(1);
            k_in    = k_ff + SPAN_W'(1);
         end
         S_FEVAL: begin
            if (!hd_rd.valid) begin
               status_in = ST_INVALID_FREE;
            end else if (hd_rd.freed) begin
               status_in = ST_DOUBLE_FREE;
            end else begin
               hd_wr_en   = 1'b1;
               hd_wr_addr = hg_ff;
               hd_wr_data = '{valid: 1'b1, freed: 1'b1, size: hd_rd.size};
               in_use_in  = in_use_ff - hd_rd.size;
               gptr_in    = off_ff[GSH +: G_W];
               cnt_in     = (SPAN_W'(hd_rd.size) + SPAN_W'(GRANULE_BYTES - 1)) >> GSH;
            end
         end
         S_FMARK: begin
            sh_wr_en   = 1'b1;
            sh_wr_data = CODE_FREED;
            gptr_in    = gptr_ff + G_W'(1);
            k_in       = k_ff + SPAN_W'(1);
         end
         S_CRD: begin
            // Bytes past the arena end are overflow.
            if (b_ff >= SPAN_W'(ARENA_BYTES)) begin
               status_in = ST_OVERFLOW;
               res_in    = addr_ff + ADDR_W'(b_ff - off_ff);
            end
         end
         S_CEVAL: begin
            b_in = gc_next;
            if (gc_fault) begin
               status_in = gc_status;
               res_in    = addr_ff + ADDR_W'(gc_fault_byte - off_ff);
            end
         end
         S_RESP: begin
            if (load_rsp) begin
               fault_in      = is_error ? fault_ff + COUNT_W'(1) : fault_ff;
               rsp_valid_in  = 1'b1;
               rsp_status_in = status_ff;
               rsp_addr_in   = res_ff;
               rsp_use_in    = in_use_ff;
               rsp_peak_in   = peak_ff;
               rsp_err_in    = is_error ? fault_ff + COUNT_W'(1) : fault_ff;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         gptr_ff      <= '0;
         base_ff      <= '0;
         break_ff     <= '0;
         ready_ff     <= 1'b0;
         in_use_ff    <= '0;
         peak_ff      <= '0;
         fault_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         gptr_ff      <= gptr_in;
         base_ff      <= base_in;
         break_ff     <= break_in;
         ready_ff     <= ready_in;
         in_use_ff    <= in_use_in;
         peak_ff      <= peak_in;
         fault_ff     <= fault_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      addr_ff       <= addr_in;
      size_ff       <= size_in;
      k_ff          <= k_in;
      cnt_ff        <= cnt_in;
      whole_ff      <= whole_in;
      tail_ff       <= tail_in;
      b_ff          <= b_in;
      e_ff          <= e_in;
      off_ff        <= off_in;
      hg_ff         <= hg_in;
      status_ff     <= status_in;
      res_ff        <= res_in;
      rsp_status_ff <= rsp_status_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_use_ff    <= rsp_use_in;
      rsp_peak_ff   <= rsp_peak_in;
      rsp_err_ff    <= rsp_err_in;
   end

   assign req_ch.ready          = (state_ff == S_IDLE);
   assign rsp_ch.valid          = rsp_valid_ff;
   assign rsp_ch.status         = rsp_status_ff;
   assign rsp_ch.result_address = rsp_addr_ff;
   assign rsp_ch.alloc_bytes    = rsp_use_ff;
   assign rsp_ch.alloc_peak     = rsp_peak_ff;
   assign rsp_ch.error_count    = rsp_err_ff;
endmodule

FILE: hdl/shc_ram.sv
// Generic single-write, single-read RAM with registered read data.
module shc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

FILE: hdl/shc_granule_check.sv
// Tests the bytes of one granule of an access against its shadow code.
module shc_granule_check
   import shc_pkg::*;
#(
   parameter int GRANULE_BYTES = GRANULE_BYTES_DEF,
   parameter int SPAN_W        = 20,
   parameter int CODE_W        = 4
) (
   input  logic [CODE_W-1:0] code,
   input  logic [SPAN_W-1:0] cur_byte,
   input  logic [SPAN_W-1:0] end_byte,
   output logic              fault,
   output status_type        fault_status,
   output logic [SPAN_W-1:0] fault_byte,
   output logic [SPAN_W-1:0] next_byte,
   output logic              last
);
   localparam int GSH = $clog2(GRANULE_BYTES);

   logic [SPAN_W-1:0] gstart;
   logic [SPAN_W-1:0] limit;
   logic [GSH-1:0]    pos;
   logic [GSH-1:0]    start_pos;

   always_comb begin
      gstart    = {cur_byte[SPAN_W-1:GSH], GSH'(0)};
      start_pos = cur_byte[GSH-1:0];
      limit     = end_byte - gstart;
      next_byte = gstart + SPAN_W'(GRANULE_BYTES);
      last      = (next_byte >= end_byte);
      pos       = start_pos;
      fault     = 1'b0;
      if (code == '0) begin
         fault = 1'b0;
      end else if (code < CODE_W'(GRANULE_BYTES)) begin
         // Partial granule: the first byte at or above the tail length faults.
         if (code[GSH-1:0] > start_pos) begin
            pos = code[GSH-1:0];
         end
         fault = (SPAN_W'(pos) < limit);
      end else begin
         fault = 1'b1;
      end
      fault_byte = gstart + SPAN_W'(pos);
      if (code == CODE_W'(GRANULE_BYTES)) begin
         fault_status = ST_UNDERFLOW;
      end else if (code == CODE_W'(GRANULE_BYTES + 2)) begin
         fault_status = ST_USE_AFTER;
      end else begin
         fault_status = ST_OVERFLOW;
      end
   end
endmodule

FILE: tb/shadow_heap_checker_tb.sv
// Self-checking testbench for the shadow heap checker, with its own shadow-memory predictor.
`timescale 1ns / 100ps

module shadow_heap_checker_tb
   import shc_pkg::*;
();

   // Geometry of the arena, matching the defaults of the block under test.
   localparam int ARENA    = ARENA_BYTES_DEF;
   localparam int GRANULE  = GRANULE_BYTES_DEF;
   localparam int REDZONE  = REDZONE_BYTES_DEF;
   localparam int GRANULES = ARENA / GRANULE;

   // Shadow codes beyond the partial-tail range.
   localparam logic [3:0] MARK_LEFT  = 4'(GRANULE);
   localparam logic [3:0] MARK_RIGHT = 4'(GRANULE + 1);
   localparam logic [3:0] MARK_FREED = 4'(GRANULE + 2);

   // The one command code that the package leaves unnamed; the block ignores it.
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   localparam int  CLK_HALF    = 4;
   localparam int  RESET_TICKS = 9;
   localparam int  DRAIN_TICKS = 40;
   localparam longint CYCLE_LIMIT = 4_000_000;

   typedef struct packed {
      logic [STATUS_W-1:0] status;
      logic [ADDR_W-1:0]   result_address;
      logic [SIZE_W-1:0]   alloc_bytes;
      logic [SIZE_W-1:0]   alloc_peak;
      logic [COUNT_W-1:0]  error_count;
   } heap_response_type;

   // A block handed out by the allocator, kept as an arena offset so that it
   // survives a change of arena_base.
   typedef struct {
      int unsigned user_offset;
      int unsigned length;
   } heap_block_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic [ADDR_W-1:0] csr_wr_data;

   shc_req_if req_bus ();
   shc_rsp_if rsp_bus ();

   shadow_heap_checker uut (
      .clock       (clock),
      .reset       (reset),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data),
      .req_ch      (req_bus.sink),
      .rsp_ch      (rsp_bus.source)
   );

   // ---------------------------------------------------------------------
   // Predictor state: our own copy of the shadow, the header table and the
   // statistics, updated once per accepted request transaction.
   // ---------------------------------------------------------------------
   logic [3:0]        shadow_model [GRANULES];
   logic              hdr_valid    [GRANULES];
   logic              hdr_freed    [GRANULES];
   logic [SIZE_W-1:0] hdr_length   [GRANULES];
   longint unsigned   arena_origin;
   longint unsigned   break_point;
   logic              heap_started;
   logic [SIZE_W-1:0] live_bytes;
   logic [SIZE_W-1:0] peak_bytes;
   logic [COUNT_W-1:0] fault_total;

   heap_response_type pending_responses [$];
   heap_block_type    issued_blocks [$];

   int  error_tally;
   logic req_taken;
   bit  steady_flow;      // when set, neither side idles
   int  rsp_stall_left;
   longint cycle_count;

   // Clock generation.
   initial begin
      clock = 1'b0;
      forever #CLK_HALF clock = ~clock;
   end

   // The watchdog stops a hung run. It prints the failure line and ends.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // An accepted request is recorded at the rising edge; the sending task reads
   // this flag at the following falling edge, so no race with the block exists.
   always @(posedge clock) begin
      req_taken <= req_bus.valid && req_bus.ready;
   end

   // ---------------------------------------------------------------------
   // Predictor functions.
   // ---------------------------------------------------------------------
   function automatic void paint_granules(longint unsigned first, longint unsigned count,
                                          logic [3:0] code);
      for (longint unsigned g = first; g < first + count && g < GRANULES; g++)
         shadow_model[g] = code;
   endfunction

   function automatic logic [3:0] predict_allocate(logic [SIZE_W-1:0] size,
                                                   output logic [ADDR_W-1:0] user_addr);
      longint unsigned want, rounded, footprint, start, g0, ug, whole, tail;
      want      = (size == 0) ? 1 : size;
      rounded   = ((want + GRANULE - 1) / GRANULE) * GRANULE;
      footprint = REDZONE + rounded + REDZONE;
      start     = break_point;
      user_addr = '0;
      heap_started = 1'b1;
      if (start + footprint > ARENA)
         return ST_NO_ROOM;
      break_point = start + footprint;
      g0 = start / GRANULE;
      paint_granules(g0, footprint / GRANULE, MARK_RIGHT);
      paint_granules(g0, REDZONE / GRANULE, MARK_LEFT);
      ug    = g0 + REDZONE / GRANULE;
      whole = want / GRANULE;
      tail  = want % GRANULE;
      paint_granules(ug, whole, 4'd0);
      if (tail != 0 && ug + whole < GRANULES)
         shadow_model[ug + whole] = 4'(tail);
      if (g0 < GRANULES) begin
         hdr_valid[g0]  = 1'b1;
         hdr_freed[g0]  = 1'b0;
         hdr_length[g0] = SIZE_W'(want);
      end
      live_bytes = live_bytes + SIZE_W'(want);
      if (live_bytes > peak_bytes)
         peak_bytes = live_bytes;
      user_addr = ADDR_W'(arena_origin + start + REDZONE);
      return ST_OK;
   endfunction

   function automatic logic [3:0] predict_free(logic [ADDR_W-1:0] addr);
      longint unsigned off, hoff, g;
      if (addr == 0 || addr < arena_origin)
         return ST_NOT_OWNED;
      off = longint'(addr) - arena_origin;
      if (off >= ARENA)
         return ST_NOT_OWNED;
      if (off < REDZONE)
         return ST_INVALID_FREE;
      hoff = off - REDZONE;
      if (hoff % GRANULE != 0)
         return ST_INVALID_FREE;
      g = hoff / GRANULE;
      if (g >= GRANULES || !hdr_valid[g])
         return ST_INVALID_FREE;
      if (hdr_freed[g])
         return ST_DOUBLE_FREE;
      hdr_freed[g] = 1'b1;
      live_bytes = live_bytes - hdr_length[g];
      paint_granules(off / GRANULE, (longint'(hdr_length[g]) + GRANULE - 1) / GRANULE,
                     MARK_FREED);
      return ST_OK;
   endfunction

   function automatic logic [3:0] predict_check(logic [ADDR_W-1:0] addr,
                                                logic [SIZE_W-1:0] size,
                                                output logic [ADDR_W-1:0] fault_addr);
      longint unsigned off, b;
      logic [3:0] code;
      fault_addr = '0;
      if (!heap_started || addr < arena_origin)
         return ST_IGNORED;
      off = longint'(addr) - arena_origin;
      if (off >= ARENA)
         return ST_IGNORED;
      for (longint unsigned i = 0; i < size; i++) begin
         b = off + i;
         if (b >= ARENA) begin
            fault_addr = ADDR_W'(longint'(addr) + i);
            return ST_OVERFLOW;
         end
         code = shadow_model[b / GRANULE];
         if (code == 0)
            continue;
         if (code < GRANULE && (b % GRANULE) < code)
            continue;
         fault_addr = ADDR_W'(longint'(addr) + i);
         if (code == MARK_LEFT)
            return ST_UNDERFLOW;
         if (code == MARK_FREED)
            return ST_USE_AFTER;
         return ST_OVERFLOW;
      end
      return ST_OK;
   endfunction

   function automatic heap_response_type predict_response(logic [CMD_W-1:0] command,
                                                          logic [ADDR_W-1:0] addr,
                                                          logic [SIZE_W-1:0] size);
      heap_response_type r;
      logic [ADDR_W-1:0] ra;
      ra = '0;
      case (command)
         CMD_ALLOC: r.status = predict_allocate(size, ra);
         CMD_FREE:  r.status = predict_free(addr);
         CMD_CHECK: r.status = predict_check(addr, size, ra);
         default:   r.status = ST_IGNORED;
      endcase
      // Underflow up to double free are genuine faults and bump the counter.
      if (r.status >= ST_UNDERFLOW && r.status <= ST_DOUBLE_FREE)
         fault_total = fault_total + 1'b1;
      r.result_address = ra;
      r.alloc_bytes    = live_bytes;
      r.alloc_peak     = peak_bytes;
      r.error_count    = fault_total;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Idling: mostly short gaps, the odd long one, none in a steady stretch.
   // ---------------------------------------------------------------------
   function automatic int pick_gap();
      int r;
      if (steady_flow)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(10, 60);
   endfunction

   // Response side: the ready line stalls at random.
   initial begin
      rsp_bus.ready  = 1'b0;
      rsp_stall_left = 0;
      forever begin
         @(negedge clock);
         if (rsp_stall_left > 0) begin
            rsp_bus.ready  = 1'b0;
            rsp_stall_left = rsp_stall_left - 1;
         end else begin
            rsp_bus.ready = 1'b1;
            if (!steady_flow && $urandom_range(0, 5) == 0)
               rsp_stall_left = pick_gap();
         end
      end
   end

   // Response checker: each completed response transaction is compared with
   // the oldest prediction. Fields are sampled at the rising edge.
   always @(posedge clock) begin
      heap_response_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         if (pending_responses.size() == 0) begin
            $error("response with no request outstanding: status %0d", rsp_bus.status);
            error_tally++;
         end else begin
            want = pending_responses.pop_front();
            if (rsp_bus.status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_bus.status);
               error_tally++;
            end
            if (rsp_bus.result_address !== want.result_address) begin
               $error("result_address: expected %h, got %h",
                      want.result_address, rsp_bus.result_address);
               error_tally++;
            end
            if (rsp_bus.alloc_bytes !== want.alloc_bytes) begin
               $error("alloc_bytes: expected %0d, got %0d",
                      want.alloc_bytes, rsp_bus.alloc_bytes);
               error_tally++;
            end
            if (rsp_bus.alloc_peak !== want.alloc_peak) begin
               $error("alloc_peak: expected %0d, got %0d",
                      want.alloc_peak, rsp_bus.alloc_peak);
               error_tally++;
            end
            if (rsp_bus.error_count !== want.error_count) begin
               $error("error_count: expected %0d, got %0d",
                      want.error_count, rsp_bus.error_count);
               error_tally++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Shared tasks.
   // ---------------------------------------------------------------------

   // Offers one request transaction, waits for the handshake and then records
   // the prediction. A granted allocation is remembered for later frees/checks.
   task automatic send_request(logic [CMD_W-1:0] command, logic [ADDR_W-1:0] addr,
                               logic [SIZE_W-1:0] size);
      heap_response_type r;
      heap_block_type blk;
      repeat (pick_gap()) begin
         @(negedge clock);
         req_bus.valid = 1'b0;
      end
      if (!req_bus.valid)
         @(negedge clock);
      req_bus.command = command;
      req_bus.address = addr;
      req_bus.size    = size;
      req_bus.valid   = 1'b1;
      do
         @(negedge clock);
      while (!req_taken);
      req_bus.valid = 1'b0;
      r = predict_response(command, addr, size);
      pending_responses.push_back(r);
      if (command == CMD_ALLOC && r.status == ST_OK) begin
         blk.user_offset = 32'(longint'(r.result_address) - arena_origin);
         blk.length      = (size == 0) ? 1 : size;
         issued_blocks.push_back(blk);
      end
   endtask

   // Waits until every response has come back, then lets the block settle.
   task automatic drain_responses();
      while (pending_responses.size() != 0)
         @(negedge clock);
      repeat (DRAIN_TICKS) @(negedge clock);
   endtask

   // Writes arena_base; only called with the block idle.
   task automatic write_arena_base(logic [ADDR_W-1:0] base);
      drain_responses();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = base;
      @(negedge clock);
      csr_wr_en    = 1'b0;
      arena_origin = base;
   endtask

   function automatic logic [ADDR_W-1:0] block_address(heap_block_type blk);
      return ADDR_W'(arena_origin + blk.user_offset);
   endfunction

   // ---------------------------------------------------------------------
   // Test tasks.
   // ---------------------------------------------------------------------

   // Before any allocation every check is ignored; command three is always ignored.
   task automatic test_before_first_allocate();
      send_request(CMD_CHECK, 32'h1000_0020, 17'd4);
      send_request(CMD_UNUSED, 32'hFFFF_FFFF, 17'h1FFFF);
      send_request(CMD_FREE, 32'd0, 17'd0);
   endtask

   // Allocation shapes: zero size, partial tails, whole granules and no room.
   task automatic test_allocation_shapes();
      send_request(CMD_ALLOC, 32'd0, 17'd65536);
      send_request(CMD_ALLOC, 32'd0, 17'd0);
      send_request(CMD_ALLOC, 32'd0, 17'd7);
      send_request(CMD_ALLOC, 32'd0, 17'd8);
      send_request(CMD_ALLOC, 32'd0, 17'd13);
   endtask

   // Checks against the blocks just allocated: zero length, in bounds, the
   // left redzone, the partial tail and an access past the arena end.
   task automatic test_access_checks();
      logic [ADDR_W-1:0] a;
      a = block_address(issued_blocks[3]);
      send_request(CMD_CHECK, a, 17'd0);
      send_request(CMD_CHECK, a, 17'd13);
      send_request(CMD_CHECK, a - 1, 17'd2);
      send_request(CMD_CHECK, a + 10, 17'd4);
      send_request(CMD_CHECK, a + 16, 17'd1);
      send_request(CMD_CHECK, ADDR_W'(arena_origin + ARENA - 1), 17'd2);
      send_request(CMD_CHECK, ADDR_W'(arena_origin + ARENA), 17'd1);
   endtask

   // Free cases: good, double, misaligned, redzone, null and foreign pointers,
   // followed by a use after free.
   task automatic test_free_cases();
      logic [ADDR_W-1:0] a;
      a = block_address(issued_blocks[1]);
      send_request(CMD_FREE, a, 17'd0);
      send_request(CMD_FREE, a, 17'd0);
      send_request(CMD_FREE, a + 4, 17'd0);
      send_request(CMD_FREE, ADDR_W'(arena_origin + 8), 17'd0);
      send_request(CMD_FREE, 32'd0, 17'd0);
      send_request(CMD_FREE, ADDR_W'(arena_origin + ARENA), 17'd0);
      send_request(CMD_CHECK, a + 3, 17'd8);
   endtask

   // A random mix weighted towards well-formed traffic on live blocks.
   task automatic test_random_traffic(int count);
      int r, s;
      logic [ADDR_W-1:0] a;
      logic [SIZE_W-1:0] n;
      heap_block_type blk;
      for (int k = 0; k < count; k++) begin
         steady_flow = ((k / 100) % 4 == 3);
         r = $urandom_range(0, 99);
         s = $urandom_range(0, 99);
         if (issued_blocks.size() != 0)
            blk = issued_blocks[$urandom_range(0, issued_blocks.size() - 1)];
         if (r < 28) begin
            if (s < 85)
               n = SIZE_W'($urandom_range(0, 40));
            else if (s < 98)
               n = SIZE_W'($urandom_range(41, 600));
            else
               n = SIZE_W'($urandom_range(0, 65536));
            send_request(CMD_ALLOC, $urandom, n);
         end else if (r < 45) begin
            if (issued_blocks.size() != 0 && s < 60)
               a = block_address(blk);
            else if (issued_blocks.size() != 0 && s < 78)
               a = block_address(blk) + $urandom_range(1, 24);
            else if (s < 85)
               a = '0;
            else
               a = $urandom;
            send_request(CMD_FREE, a, 17'($urandom));
         end else if (r < 95) begin
            if (issued_blocks.size() != 0 && s < 85)
               a = block_address(blk) - 20 + $urandom_range(0, blk.length + 40);
            else if (s < 92)
               a = ADDR_W'(arena_origin + $urandom_range(0, ARENA - 1));
            else
               a = $urandom;
            n = ($urandom_range(0, 19) == 0) ? SIZE_W'($urandom_range(0, 65536))
                                              : SIZE_W'($urandom_range(0, 24));
            send_request(CMD_CHECK, a, n);
         end else begin
            send_request(CMD_UNUSED, $urandom, 17'($urandom));
         end
      end
      steady_flow = 1'b0;
   endtask

   // ---------------------------------------------------------------------
   // Sequence of the run.
   // ---------------------------------------------------------------------
   initial begin
      reset         = 1'b1;
      csr_wr_en     = 1'b0;
      csr_wr_data   = '0;
      req_bus.valid   = 1'b0;
      req_bus.command = CMD_ALLOC;
      req_bus.address = '0;
      req_bus.size    = '0;
      error_tally   = 0;
      steady_flow   = 1'b0;
      cycle_count   = 0;
      arena_origin  = 0;
      break_point   = 0;
      heap_started  = 1'b0;
      live_bytes    = '0;
      peak_bytes    = '0;
      fault_total   = '0;
      for (int g = 0; g < GRANULES; g++) begin
         shadow_model[g] = MARK_LEFT;
         hdr_valid[g]    = 1'b0;
         hdr_freed[g]    = 1'b0;
         hdr_length[g]   = '0;
      end
      repeat (RESET_TICKS) @(negedge clock);
      reset = 1'b0;

      write_arena_base(32'h1000_0000);
      test_before_first_allocate();
      test_allocation_shapes();
      test_access_checks();
      test_free_cases();
      test_random_traffic(800);

      // The lowest base, where address zero is the first arena byte.
      write_arena_base(32'h0000_0000);
      test_random_traffic(500);

      // The highest aligned base: the arena wraps past the top of the bus.
      write_arena_base(32'hFFFF_FFF8);
      test_random_traffic(100);

      write_arena_base({29'($urandom_range(0, 32'h1FFF_FFFF)), 3'b000});
      test_random_traffic(600);

      drain_responses();
      if (error_tally == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
